### rtl/core/gift_wrap_convex_hull_top_macros.svh
// Assertion macros for the convex hull block
`ifndef GIFT_WRAP_CONVEX_HULL_TOP_MACROS_SVH
`define GIFT_WRAP_CONVEX_HULL_TOP_MACROS_SVH

// same-cycle implication
`define GWCH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GWCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/gwch_pkg.sv
// Shared types, constants and helpers for the convex hull block
package gwch_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int MIN_POINTS = 3;

   typedef logic signed [COORD_BITS-1:0]   coord_type;
   typedef logic signed [COORD_BITS:0]     delta_type;
   typedef logic [COORD_BITS:0]            dist_type;
   typedef logic signed [2*COORD_BITS+1:0] prod_type;
   typedef logic signed [2*COORD_BITS+2:0] cross_type;
   typedef logic [IDX_BITS-1:0]            idx_type;
   typedef logic [CNT_BITS-1:0]            cnt_type;
   typedef logic [1:0]                     status_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_TOO_FEW  = 2'd1;
   localparam status_type STATUS_DROPPED  = 2'd2;
   localparam status_type STATUS_WALK_OVF = 2'd3;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      logic      start;
      delta_type cand_dx;
      delta_type cand_dy;
      delta_type pt_dx;
      delta_type pt_dy;
      dist_type  cand_dist;
      dist_type  pt_dist;
   } orient_req_type;

   typedef struct packed {
      logic done;
      logic replace;
   } orient_rsp_type;

   function automatic delta_type delta_of(coord_type a, coord_type b);
      return delta_type'(a) - delta_type'(b);
   endfunction

   // magnitude of a coordinate difference never exceeds 2**COORD_BITS - 1
   function automatic logic [COORD_BITS-1:0] abs_delta(delta_type d);
      delta_type m;
      m = (d < 0) ? -d : d;
      return m[COORD_BITS-1:0];
   endfunction

endpackage

### rtl/core/gwch_req_if.sv
// Point input channel
interface gwch_req_if import gwch_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type first_coord;
   coord_type second_coord;
   logic      last_point;

   modport source (output valid, first_coord, second_coord, last_point, input ready);
   modport sink   (input valid, first_coord, second_coord, last_point, output ready);
endinterface

### rtl/core/gwch_rsp_if.sv
// Hull vertex result channel
interface gwch_rsp_if import gwch_pkg::*; ();
   logic       valid;
   logic       ready;
   coord_type  hull_first;
   coord_type  hull_second;
   logic       end_of_hull;
   status_type status;

   modport source (output valid, hull_first, hull_second, end_of_hull, status, input ready);
   modport sink   (input valid, hull_first, hull_second, end_of_hull, status, output ready);
endinterface

### rtl/core/gift_wrap_convex_hull_top.sv
// Top level of the gift-wrapping convex hull block.
// Points arrive one word per cycle on req; the word with last_point set closes
// the set. Up to 64 points are stored; further points are dropped and every
// vertex of that hull then carries status 2 (dropped).
// After the last point the block is busy: it finds the start point by reading
// and comparing each point in turn, swaps it with the point in slot 0, then
// walks the hull. Each walk step loads the candidate, then for every point
// other than the current vertex reads it through the single read port of the
// point store and runs the orientation test on the single shared multiplier
// (two products, then compare); the step then closes on the chosen candidate.
// Vertices are held in a hull buffer and sent on rsp after the walk closes;
// each is read out, then registered; the last carries end_of_hull. Fewer than 3
// points or a walk longer than the point count give a single error word.
// req.ready is high only while the block is idle, so throughput while loading
// is one point per cycle. A stalled rsp holds its word in the output register;
// the block may take the next set while that word waits.
// Synchronous reset empties the set and drops any pending word; store contents
// are not cleared and are never read before being written.
`include "gift_wrap_convex_hull_top_macros.svh"

module gift_wrap_convex_hull_top import gwch_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gwch_req_if.sink    req,
   gwch_rsp_if.source  rsp
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FIND_RD, ST_FIND_CMP, ST_SWAP_A, ST_SWAP_B,
      ST_STEP_RD, ST_STEP_LD, ST_SCAN_RD, ST_SCAN_LD, ST_SCAN_GO,
      ST_SCAN_WAIT, ST_STEP_END, ST_EMIT_RD, ST_EMIT_LD, ST_ERR
   } state_type;

   state_type  state_ff, state_in;
   cnt_type    count_ff, count_in;
   logic       dropped_ff, dropped_in;
   cnt_type    n_ff, n_in;
   status_type st_ff, st_in;
   status_type err_status_ff, err_status_in;
   idx_type    scan_ff, scan_in;
   idx_type    start_idx_ff, start_idx_in;
   point_type  start_pt_ff, start_pt_in;
   point_type  p0_ff, p0_in;
   idx_type    cur_ff, cur_in;
   idx_type    cidx_ff, cidx_in;
   point_type  o_ff, o_in;
   point_type  cand_ff, cand_in;
   delta_type  cand_dx_ff, cand_dx_in;
   delta_type  cand_dy_ff, cand_dy_in;
   dist_type   cand_dist_ff, cand_dist_in;
   point_type  p_ff, p_in;
   delta_type  p_dx_ff, p_dx_in;
   delta_type  p_dy_ff, p_dy_in;
   dist_type   p_dist_ff, p_dist_in;
   cnt_type    hull_cnt_ff, hull_cnt_in;
   idx_type    emit_ff, emit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   point_type  rsp_pt_ff, rsp_pt_in;
   logic       rsp_end_ff, rsp_end_in;
   status_type rsp_status_ff, rsp_status_in;

   // point store and hull buffer
   point_type  pt_mem [MAX_POINTS];
   point_type  hb_mem [MAX_POINTS];
   logic       pt_we, hb_we;
   idx_type    pt_wa, pt_ra, hb_wa;
   point_type  pt_wd, hb_wd;
   point_type  pt_rd_ff, hb_rd_ff;

   orient_req_type orient_req;
   orient_rsp_type orient_rsp;

   cnt_type    n_new;
   logic       drop_new;
   cnt_type    nxt_cnt;
   idx_type    nxt_idx;
   logic       scan_last;
   logic       emit_last;
   logic       out_free;
   delta_type  rd_dx, rd_dy;
   dist_type   rd_dist;

   gwch_orient u_orient (
      .clock      (clock),
      .reset      (reset),
      .orient_req (orient_req),
      .orient_rsp (orient_rsp)
   );

   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[pt_wa] <= pt_wd;
      pt_rd_ff <= pt_mem[pt_ra];
   end

   always_ff @(posedge clock) begin
      if (hb_we) hb_mem[hb_wa] <= hb_wd;
      hb_rd_ff <= hb_mem[emit_ff];
   end

   assign nxt_cnt   = {1'b0, cur_ff} + cnt_type'(1);
   assign nxt_idx   = (nxt_cnt < n_ff) ? nxt_cnt[IDX_BITS-1:0] : '0;
   assign scan_last = ({1'b0, scan_ff} == (n_ff - cnt_type'(1)));
   assign emit_last = ({1'b0, emit_ff} == (hull_cnt_ff - cnt_type'(1)));
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign rd_dx     = delta_of(pt_rd_ff.x, o_ff.x);
   assign rd_dy     = delta_of(pt_rd_ff.y, o_ff.y);
   assign rd_dist   = dist_type'(abs_delta(rd_dx)) + dist_type'(abs_delta(rd_dy));

   always_comb begin
      orient_req.start     = (state_ff == ST_SCAN_GO);
      orient_req.cand_dx   = cand_dx_ff;
      orient_req.cand_dy   = cand_dy_ff;
      orient_req.pt_dx     = p_dx_ff;
      orient_req.pt_dy     = p_dy_ff;
      orient_req.cand_dist = cand_dist_ff;
      orient_req.pt_dist   = p_dist_ff;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      n_in          = n_ff;
      st_in         = st_ff;
      err_status_in = err_status_ff;
      scan_in       = scan_ff;
      start_idx_in  = start_idx_ff;
      start_pt_in   = start_pt_ff;
      p0_in         = p0_ff;
      cur_in        = cur_ff;
      cidx_in       = cidx_ff;
      o_in          = o_ff;
      cand_in       = cand_ff;
      cand_dx_in    = cand_dx_ff;
      cand_dy_in    = cand_dy_ff;
      cand_dist_in  = cand_dist_ff;
      p_in          = p_ff;
      p_dx_in       = p_dx_ff;
      p_dy_in       = p_dy_ff;
      p_dist_in     = p_dist_ff;
      hull_cnt_in   = hull_cnt_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_pt_in     = rsp_pt_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_status_in = rsp_status_ff;
      pt_we         = 1'b0;
      pt_wa         = count_ff[IDX_BITS-1:0];
      pt_wd         = '{x: req.first_coord, y: req.second_coord};
      pt_ra         = scan_ff;
      hb_we         = 1'b0;
      hb_wa         = hull_cnt_ff[IDX_BITS-1:0];
      hb_wd         = cand_ff;
      n_new         = count_ff;
      drop_new      = dropped_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid && !reset) begin
               if (count_ff < cnt_type'(MAX_POINTS)) begin
                  pt_we = 1'b1;
                  n_new = count_ff + cnt_type'(1);
               end else begin
                  drop_new = 1'b1;
               end
               if (req.last_point) begin
                  n_in       = n_new;
                  st_in      = drop_new ? STATUS_DROPPED : STATUS_OK;
                  count_in   = '0;
                  dropped_in = 1'b0;
                  scan_in    = '0;
                  if (n_new < cnt_type'(MIN_POINTS)) begin
                     err_status_in = STATUS_TOO_FEW;
                     state_in      = ST_ERR;
                  end else begin
                     state_in = ST_FIND_RD;
                  end
               end else begin
                  count_in   = n_new;
                  dropped_in = drop_new;
               end
            end
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            if (scan_ff == '0) begin
               p0_in        = pt_rd_ff;
               start_pt_in  = pt_rd_ff;
               start_idx_in = '0;
            end else if ((pt_rd_ff.x < start_pt_ff.x) ||
                         ((pt_rd_ff.x == start_pt_ff.x) && (pt_rd_ff.y <= start_pt_ff.y))) begin
               start_pt_in  = pt_rd_ff;
               start_idx_in = scan_ff;
            end
            if (scan_last) begin
               state_in = ST_SWAP_A;
            end else begin
               scan_in  = scan_ff + idx_type'(1);
               state_in = ST_FIND_RD;
            end
         end
         ST_SWAP_A: begin
            pt_we    = 1'b1;
            pt_wa    = '0;
            pt_wd    = start_pt_ff;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            pt_we       = 1'b1;
            pt_wa       = start_idx_ff;
            pt_wd       = p0_ff;
            hb_we       = 1'b1;
            hb_wa       = '0;
            hb_wd       = start_pt_ff;
            o_in        = start_pt_ff;
            cur_in      = '0;
            hull_cnt_in = cnt_type'(1);
            state_in    = ST_STEP_RD;
         end
         ST_STEP_RD: begin
            pt_ra    = nxt_idx;
            cidx_in  = nxt_idx;
            state_in = ST_STEP_LD;
         end
         ST_STEP_LD: begin
            cand_in      = pt_rd_ff;
            cand_dx_in   = rd_dx;
            cand_dy_in   = rd_dy;
            cand_dist_in = rd_dist;
            scan_in      = '0;
            state_in     = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (scan_ff == cur_ff) begin
               if (scan_last) state_in = ST_STEP_END;
               else scan_in = scan_ff + idx_type'(1);
            end else begin
               state_in = ST_SCAN_LD;
            end
         end
         ST_SCAN_LD: begin
            p_in      = pt_rd_ff;
            p_dx_in   = rd_dx;
            p_dy_in   = rd_dy;
            p_dist_in = rd_dist;
            state_in  = ST_SCAN_GO;
         end
         ST_SCAN_GO: begin
            state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            if (orient_rsp.done) begin
               if (orient_rsp.replace) begin
                  cidx_in      = scan_ff;
                  cand_in      = p_ff;
                  cand_dx_in   = p_dx_ff;
                  cand_dy_in   = p_dy_ff;
                  cand_dist_in = p_dist_ff;
               end
               if (scan_last) begin
                  state_in = ST_STEP_END;
               end else begin
                  scan_in  = scan_ff + idx_type'(1);
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_STEP_END: begin
            if (cidx_ff == '0) begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end else if (hull_cnt_ff >= n_ff) begin
               err_status_in = STATUS_WALK_OVF;
               state_in      = ST_ERR;
            end else begin
               hb_we       = 1'b1;
               hull_cnt_in = hull_cnt_ff + cnt_type'(1);
               cur_in      = cidx_ff;
               o_in        = cand_ff;
               state_in    = ST_STEP_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pt_in     = hb_rd_ff;
               rsp_end_in    = emit_last;
               rsp_status_in = st_ff;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + idx_type'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pt_in     = '0;
               rsp_end_in    = 1'b1;
               rsp_status_in = err_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         cur_ff       <= '0;
         cidx_ff      <= '0;
         hull_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         cur_ff       <= cur_in;
         cidx_ff      <= cidx_in;
         hull_cnt_ff  <= hull_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      st_ff         <= st_in;
      err_status_ff <= err_status_in;
      scan_ff       <= scan_in;
      start_idx_ff  <= start_idx_in;
      start_pt_ff   <= start_pt_in;
      p0_ff         <= p0_in;
      o_ff          <= o_in;
      cand_ff       <= cand_in;
      cand_dx_ff    <= cand_dx_in;
      cand_dy_ff    <= cand_dy_in;
      cand_dist_ff  <= cand_dist_in;
      p_ff          <= p_in;
      p_dx_ff       <= p_dx_in;
      p_dy_ff       <= p_dy_in;
      p_dist_ff     <= p_dist_in;
      emit_ff       <= emit_in;
      rsp_pt_ff     <= rsp_pt_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req.ready       = (state_ff == ST_IDLE) && !reset;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hull_first  = rsp_pt_ff.x;
   assign rsp.hull_second = rsp_pt_ff.y;
   assign rsp.end_of_hull = rsp_end_ff;
   assign rsp.status      = rsp_status_ff;

   `GWCH_ASSERT_NOW(a_err_word_ends, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_TOO_FEW || rsp_status_ff == STATUS_WALK_OVF),
      rsp_end_ff, "error word without end_of_hull")
   `GWCH_ASSERT_NOW(a_orient_done_in_wait, clock, reset,
      orient_rsp.done, state_ff == ST_SCAN_WAIT, "orientation result outside scan wait")
   `GWCH_ASSERT_NOW(a_hull_cnt_bound, clock, reset,
      state_ff == ST_STEP_RD, hull_cnt_ff != '0 && hull_cnt_ff <= n_ff,
      "hull vertex count out of range")
   `GWCH_ASSERT_NEXT(a_scan_in_range, clock, reset,
      state_ff == ST_SWAP_B, n_ff >= cnt_type'(MIN_POINTS) && state_ff == ST_STEP_RD,
      "walk started on too few points")

endmodule

### rtl/core/gwch_orient.sv
// Shared multiplier unit: orientation test of a point against the candidate
module gwch_orient import gwch_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  orient_req_type orient_req,
   output orient_rsp_type orient_rsp
);

   typedef enum logic [1:0] {OR_IDLE, OR_MUL_A, OR_MUL_B, OR_CMP} or_state_type;

   or_state_type state_ff, state_in;
   prod_type     prod_a_ff, prod_a_in;
   prod_type     prod_b_ff, prod_b_in;
   delta_type    mul_l, mul_r;
   prod_type     mul_out;
   cross_type    cross_val;

   // one multiplier, two passes
   always_comb begin
      if (state_ff == OR_MUL_A) begin
         mul_l = orient_req.cand_dx;
         mul_r = orient_req.pt_dy;
      end else begin
         mul_l = orient_req.pt_dx;
         mul_r = orient_req.cand_dy;
      end
   end

   assign mul_out   = prod_type'(mul_l) * prod_type'(mul_r);
   assign cross_val = cross_type'(prod_a_ff) - cross_type'(prod_b_ff);

   always_comb begin
      state_in  = state_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      case (state_ff)
         OR_IDLE: begin
            if (orient_req.start) state_in = OR_MUL_A;
         end
         OR_MUL_A: begin
            prod_a_in = mul_out;
            state_in  = OR_MUL_B;
         end
         OR_MUL_B: begin
            prod_b_in = mul_out;
            state_in  = OR_CMP;
         end
         OR_CMP: begin
            state_in = OR_IDLE;
         end
         default: state_in = OR_IDLE;
      endcase
   end

   always_comb begin
      orient_rsp.done    = (state_ff == OR_CMP);
      orient_rsp.replace = (cross_val > 0) ||
                           ((cross_val == 0) && (orient_req.pt_dist >= orient_req.cand_dist));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
   end

endmodule

### dv/tb_gift_wrap_convex_hull_top.sv
// Testbench for gift_wrap_convex_hull_top: streamed point sets checked against a hull predictor
module tb_gift_wrap_convex_hull_top import gwch_pkg::*; ();

   typedef struct {
      coord_type x;
      coord_type y;
      bit        closes;
      bit        drain;
   } point_word_type;

   typedef struct {
      coord_type  x;
      coord_type  y;
      logic       eoh;
      status_type st;
   } hull_word_type;

   logic clock;
   logic reset;

   gwch_req_if req_bus ();
   gwch_rsp_if rsp_bus ();

   gift_wrap_convex_hull_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   point_word_type pending_points[$];
   hull_word_type  hull_expect[$];
   point_type      set_store[MAX_POINTS];
   int             set_count    = 0;
   bit             set_lost     = 1'b0;
   int             errors       = 0;
   int             tx_gap       = 0;
   int             rx_stall     = 0;
   bit             tx_calm      = 1'b0;
   bit             rx_calm      = 1'b0;
   int             random_items = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.first_coord  = '0;
      req_bus.second_coord = '0;
      req_bus.last_point   = 1'b0;
      rsp_bus.ready        = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // mostly short gaps, a few long, none at all while calm
   function automatic int next_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint manhattan_span(point_type a, point_type b);
      longint dx, dy;
      dx = longint'(a.x) - longint'(b.x);
      dy = longint'(a.y) - longint'(b.y);
      return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
   endfunction

   // point p takes over from candidate c as seen from vertex o
   function automatic bit overtakes(int o, int p, int c);
      longint turn;
      turn = (longint'(set_store[c].x) - longint'(set_store[o].x))
           * (longint'(set_store[p].y) - longint'(set_store[o].y))
           - (longint'(set_store[p].x) - longint'(set_store[o].x))
           * (longint'(set_store[c].y) - longint'(set_store[o].y));
      if (turn > 0) return 1'b1;
      if (turn < 0) return 1'b0;
      return manhattan_span(set_store[o], set_store[p]) >=
             manhattan_span(set_store[o], set_store[c]);
   endfunction

   function automatic void expect_error(status_type st);
      hull_word_type w;
      w.x   = '0;
      w.y   = '0;
      w.eoh = 1'b1;
      w.st  = st;
      hull_expect.push_back(w);
   endfunction

   function automatic hull_word_type vertex_word(int idx, status_type st);
      hull_word_type w;
      w.x   = set_store[idx].x;
      w.y   = set_store[idx].y;
      w.eoh = 1'b0;
      w.st  = st;
      return w;
   endfunction

   function automatic void predict_point(point_word_type w);
      int            n, start, cur, cand;
      status_type    st;
      point_type     tmp;
      hull_word_type walk[$];
      bit            ovf;
      if (set_count < MAX_POINTS) begin
         set_store[set_count].x = w.x;
         set_store[set_count].y = w.y;
         set_count++;
      end else begin
         set_lost = 1'b1;
      end
      if (!w.closes) return;
      n = set_count;
      st = set_lost ? STATUS_DROPPED : STATUS_OK;
      set_count = 0;
      set_lost = 1'b0;
      if (n < MIN_POINTS) begin
         expect_error(STATUS_TOO_FEW);
         return;
      end
      start = 0;
      for (int i = 0; i < n; i++) begin
         if (set_store[i].x < set_store[start].x) begin
            start = i;
         end else if (set_store[i].x == set_store[start].x &&
                      set_store[i].y <= set_store[start].y) begin
            start = i;
         end
      end
      tmp = set_store[0];
      set_store[0] = set_store[start];
      set_store[start] = tmp;
      walk.push_back(vertex_word(0, st));
      cur = 0;
      ovf = 1'b0;
      do begin
         cand = (cur + 1) % n;
         for (int i = 0; i < n; i++) begin
            if (i != cur && overtakes(cur, i, cand)) cand = i;
         end
         cur = cand;
         if (cur != 0) begin
            if (walk.size() >= n) ovf = 1'b1;
            else walk.push_back(vertex_word(cur, st));
         end
      end while (cur != 0 && !ovf);
      if (ovf) begin
         expect_error(STATUS_WALK_OVF);
      end else begin
         walk[walk.size() - 1].eoh = 1'b1;
         foreach (walk[i]) hull_expect.push_back(walk[i]);
      end
   endfunction

   function automatic void add_point(int x, int y, bit closes, bit drain = 1'b0);
      point_word_type w;
      w.x      = coord_type'(x);
      w.y      = coord_type'(y);
      w.closes = closes;
      w.drain  = drain;
      pending_points.push_back(w);
   endfunction

   // 0: full range, 1: small box (collinear and repeated points), 2: extremes and values around zero
   function automatic coord_type pick_coord(int mode);
      int edges[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      if (mode == 1) return coord_type'(int'($urandom_range(0, 8)) - 4);
      if (mode == 2) return coord_type'(edges[$urandom_range(0, 6)]);
      return coord_type'($urandom_range(0, 65535));
   endfunction

   always @(posedge clock) begin : point_driver
      bit present;
      if (reset) begin
         req_bus.valid <= 1'b0;
         tx_gap = 0;
      end else begin
         present = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            predict_point(pending_points.pop_front());
            present = 1'b0;
         end
         if (!present && pending_points.size() != 0) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (!(pending_points[0].drain && hull_expect.size() != 0)) begin
               present = 1'b1;
               if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
               tx_gap = next_gap(tx_calm);
            end
         end
         req_bus.valid <= present;
         if (present) begin
            req_bus.first_coord  <= pending_points[0].x;
            req_bus.second_coord <= pending_points[0].y;
            req_bus.last_point   <= pending_points[0].closes;
         end
      end
   end

   always @(posedge clock) begin : hull_monitor
      hull_word_type want;
      bit            took;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_stall = 0;
      end else begin
         took = rsp_bus.valid && rsp_bus.ready;
         if (took) begin
            if (hull_expect.size() == 0) begin
               $display("%0t: unexpected hull word (%0d, %0d) end %0b status %0d", $time,
                        rsp_bus.hull_first, rsp_bus.hull_second, rsp_bus.end_of_hull,
                        rsp_bus.status);
               errors++;
            end else begin
               want = hull_expect.pop_front();
               if (rsp_bus.hull_first !== want.x || rsp_bus.hull_second !== want.y ||
                   rsp_bus.end_of_hull !== want.eoh || rsp_bus.status !== want.st) begin
                  $display("%0t: hull word mismatch, expected (%0d, %0d) end %0b status %0d, %s",
                           $time, want.x, want.y, want.eoh, want.st, "got:");
                  $display("%0t:    actual (%0d, %0d) end %0b status %0d", $time,
                           rsp_bus.hull_first, rsp_bus.hull_second, rsp_bus.end_of_hull,
                           rsp_bus.status);
                  errors++;
               end
            end
         end
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (took || $urandom_range(0, 7) == 0) begin
               if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
               rx_stall = next_gap(rx_calm);
            end
         end
      end
   end

   initial begin : stimulus
      int n, r, mode;
      bit drain;
      // too few points
      add_point(0, 0, 1'b1);
      add_point(32767, -32768, 1'b0);
      add_point(-32768, 32767, 1'b1);
      // extreme triangle
      add_point(-32768, -32768, 1'b0);
      add_point(32767, -32768, 1'b0);
      add_point(0, 32767, 1'b1);
      // full square, interior point, points on the edges
      add_point(32767, 32767, 1'b0);
      add_point(-32768, 32767, 1'b0);
      add_point(-32768, -32768, 1'b0);
      add_point(32767, -32768, 1'b0);
      add_point(0, 0, 1'b0);
      add_point(0, 32767, 1'b0);
      add_point(-32768, 0, 1'b1);
      // start point tie, repeated point at the start
      add_point(-5, 3, 1'b0);
      add_point(-5, -2, 1'b0);
      add_point(-5, -2, 1'b0);
      add_point(4, 0, 1'b0);
      add_point(0, 6, 1'b1);
      // repeated points overflow the walk; sent only once the block has drained
      add_point(7, 7, 1'b0, 1'b1);
      add_point(7, 7, 1'b0);
      add_point(7, 7, 1'b1);
      // collinear set
      add_point(0, 0, 1'b0);
      add_point(10, 10, 1'b0);
      add_point(-10, -10, 1'b1);

      // more points than the store holds
      n = MAX_POINTS + $urandom_range(2, 5);
      for (int k = 0; k < n; k++) add_point(pick_coord(0), pick_coord(0), k == n - 1);
      random_items += n;
      while (random_items < 96) begin
         r = $urandom_range(0, 9);
         n = (r == 0) ? $urandom_range(1, 2) : (r < 8) ? $urandom_range(3, 10)
                                                       : $urandom_range(11, 24);
         mode = $urandom_range(0, 2);
         drain = ($urandom_range(0, 9) == 0);
         for (int k = 0; k < n; k++) begin
            add_point(pick_coord(mode), pick_coord(mode), k == n - 1, drain && k == 0);
         end
         random_items += n;
      end

      @(negedge reset);
      while (pending_points.size() != 0 || req_bus.valid) @(posedge clock);
      while (hull_expect.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
